### hdl/aip_pkg.sv
package aip_pkg;

    localparam int CHAR_W       = 8;
    localparam int BASE_W       = 6;
    localparam int DIGIT_W      = 6;
    localparam int VALUE_W      = 64;
    localparam int END_W        = 13;
    localparam int STATUS_W     = 2;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 80;
    localparam int OUT_PAD_W    = OUT_TDATA_W - VALUE_W - END_W - STATUS_W;

    localparam int MAX_LENGTH_DEF  = 4096;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [BASE_W-1:0] BASE_RESET   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_DETECT  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE     = 6'd1;
    localparam logic [BASE_W-1:0] BASE_OCT     = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC     = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX     = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX     = 6'd36;

    localparam logic [DIGIT_W-1:0] NO_DIGIT    = 6'd36;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'd0;
    localparam logic [CHAR_W-1:0] CH_NL      = 8'd10;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'd57;
    localparam logic [CHAR_W-1:0] CH_UP_A    = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UP_X    = 8'd88;
    localparam logic [CHAR_W-1:0] CH_UP_Z    = 8'd90;
    localparam logic [CHAR_W-1:0] CH_LO_A    = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LO_X    = 8'd120;
    localparam logic [CHAR_W-1:0] CH_LO_Z    = 8'd122;
    localparam logic [CHAR_W-1:0] CASE_GAP   = 8'd32;
    localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd55;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BADBASE = 2'd2;

    localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

    // one classified character, front to back
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               is_nul;
        logic               is_nl;
        logic               is_minus;
        logic               is_plus;
        logic               is_zero;
        logic               is_x;
        logic               last;
        logic [BASE_W-1:0]  base;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [END_W-1:0]          end_index;
        logic signed [VALUE_W-1:0] value;
    } res_t;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] u;
        u = c;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            return DIGIT_W'(c - CH_ZERO);
        end
        if (c >= CH_LO_A && c <= CH_LO_Z)
        begin
            u = c - CASE_GAP;
        end
        if (u >= CH_UP_A && u <= CH_UP_Z)
        begin
            return DIGIT_W'(u - LETTER_OFS);
        end
        return NO_DIGIT;
    endfunction

    function automatic logic base_bad(input logic [BASE_W-1:0] b);
        return (b == BASE_ONE) || (b > BASE_MAX);
    endfunction

endpackage

### hdl/aip_front.sv
module aip_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [aip_pkg::BASE_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [aip_pkg::CHAR_W-1:0]     in_char,
    input  logic                           in_last,
    output logic                           cmd_valid,
    input  logic                           cmd_ready,
    output aip_pkg::cmd_t                  cmd
);
    import aip_pkg::*;

    logic [BASE_W-1:0] base_reg;

    // radix register; write it only between strings (the block does not enforce this)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
        end
        else if (cfg_we)
        begin
            base_reg <= cfg_data;
        end
    end

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;

    always_comb
    begin
        cmd.digit    = digit_of(in_char);
        cmd.is_nul   = (in_char == CH_NUL);
        cmd.is_nl    = (in_char == CH_NL);
        cmd.is_minus = (in_char == CH_MINUS);
        cmd.is_plus  = (in_char == CH_PLUS);
        cmd.is_zero  = (in_char == CH_ZERO);
        cmd.is_x     = (in_char == CH_LO_X) || (in_char == CH_UP_X);
        cmd.last     = in_last;
        cmd.base     = base_reg;
    end

endmodule

### hdl/aip_queue.sv
module aip_queue #(
    parameter int DEPTH = aip_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  aip_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop,
    output aip_pkg::cmd_t pop_data
);
    import aip_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

### hdl/aip_back.sv
module aip_back #(
    parameter int MAX_LENGTH = aip_pkg::MAX_LENGTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    input  aip_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output aip_pkg::res_t res
);
    import aip_pkg::*;

    localparam int POS_W = $clog2(MAX_LENGTH + 1);
    localparam int PH_W  = 3;
    localparam int SUM_W = VALUE_W + BASE_W + 1;

    localparam logic [PH_W-1:0] PH_SPACE    = 3'd0;
    localparam logic [PH_W-1:0] PH_PLUS     = 3'd1;
    localparam logic [PH_W-1:0] PH_PREFIX   = 3'd2;
    localparam logic [PH_W-1:0] PH_EXPECT_X = 3'd3;
    localparam logic [PH_W-1:0] PH_DIGITS   = 3'd4;
    localparam logic [PH_W-1:0] PH_DONE     = 3'd5;

    logic [PH_W-1:0]    phase_reg,  phase_next;
    logic [VALUE_W-1:0] acc_reg,    acc_next;
    logic [BASE_W-1:0]  base_reg,   base_next;
    logic               neg_reg,    neg_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [POS_W-1:0]   cend_reg,   cend_next;
    logic               range_reg,  range_next;

    logic               out_valid_reg;
    res_t               out_reg;
    res_t               res_new;

    logic               first;
    logic               keep;
    logic [POS_W-1:0]   idx_plus;
    logic [BASE_W-1:0]  base_eff;
    logic [BASE_W-1:0]  radix;
    logic               digit_ok;
    logic [VALUE_W-1:0] limit;
    logic [SUM_W-1:0]   mac;
    logic               sat;
    logic [PH_W-1:0]    ph;
    logic               handled;
    logic               use_digit;
    logic [VALUE_W-1:0] mag;

    // a result needs the output register free; other characters never wait
    assign cmd_pop = cmd_valid && (!cmd.last || !out_valid_reg || res_ready);

    assign first    = (pos_reg == '0);
    assign keep     = (pos_reg < POS_W'(MAX_LENGTH));
    assign idx_plus = pos_reg + POS_W'(1);
    assign base_eff = first ? cmd.base : base_reg;
    assign radix    = (base_eff == BASE_DETECT) ? BASE_DEC : base_eff;
    assign digit_ok = (cmd.digit < radix);
    assign limit    = neg_reg ? NEG_LIMIT : POS_LIMIT;

    // acc*radix + d > limit is the same test as acc > (limit - d) / radix
    assign mac = SUM_W'(acc_reg) * SUM_W'(radix) + SUM_W'(cmd.digit);
    assign sat = (mac > SUM_W'(limit));

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        neg_next   = neg_reg;
        pos_next   = pos_reg;
        cend_next  = cend_reg;
        range_next = range_reg;
        ph         = phase_reg;
        handled    = 1'b0;
        use_digit  = 1'b0;
        mag        = '0;
        res_new    = '0;

        if (cmd_pop)
        begin
            if (first)
            begin
                base_next = cmd.base;
                if (base_bad(cmd.base))
                begin
                    phase_next = PH_DONE;
                    ph         = PH_DONE;
                end
            end

            if (keep)
            begin
                pos_next = idx_plus;
                if (ph == PH_DONE)
                begin
                    handled = 1'b1;
                end
                else if (cmd.is_nul)
                begin
                    phase_next = PH_DONE;
                    handled    = 1'b1;
                end

                if (!handled && ph == PH_SPACE)
                begin
                    if (cmd.is_nl)
                    begin
                        handled = 1'b1;
                    end
                    else if (cmd.is_minus)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_PLUS;
                        handled    = 1'b1;
                    end
                    else
                    begin
                        ph = PH_PLUS;
                    end
                end

                if (!handled && ph == PH_PLUS)
                begin
                    if (cmd.is_plus)
                    begin
                        phase_next = PH_PREFIX;
                        handled    = 1'b1;
                    end
                    else
                    begin
                        ph = PH_PREFIX;
                    end
                end

                if (!handled && ph == PH_PREFIX)
                begin
                    handled = 1'b1;
                    if (cmd.is_zero && (base_eff == BASE_DETECT || base_eff == BASE_HEX))
                    begin
                        if (base_eff == BASE_DETECT)
                        begin
                            base_next = BASE_OCT;
                        end
                        cend_next  = idx_plus;
                        phase_next = PH_EXPECT_X;
                    end
                    else
                    begin
                        use_digit = 1'b1;
                    end
                end

                if (!handled && ph == PH_EXPECT_X)
                begin
                    handled = 1'b1;
                    if (cmd.is_x)
                    begin
                        base_next  = BASE_HEX;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        use_digit = 1'b1;
                    end
                end

                if (!handled)
                begin
                    use_digit = 1'b1;
                end

                if (use_digit)
                begin
                    if (!digit_ok)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        if (sat)
                        begin
                            acc_next   = limit;
                            range_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = mac[VALUE_W-1:0];
                        end
                        cend_next  = idx_plus;
                        phase_next = PH_DIGITS;
                    end
                end
            end

            if (cmd.last)
            begin
                mag = neg_next ? (VALUE_W'(0) - acc_next) : acc_next;
                if (base_bad(base_next))
                begin
                    res_new.status    = STATUS_BADBASE;
                    res_new.end_index = '0;
                    res_new.value     = '0;
                end
                else
                begin
                    res_new.status    = range_next ? STATUS_RANGE : STATUS_OK;
                    res_new.end_index = END_W'(cend_next);
                    res_new.value     = mag;
                end
                phase_next = PH_SPACE;
                acc_next   = '0;
                base_next  = '0;
                neg_next   = 1'b0;
                pos_next   = '0;
                cend_next  = '0;
                range_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SPACE;
            acc_reg       <= '0;
            base_reg      <= '0;
            neg_reg       <= 1'b0;
            pos_reg       <= '0;
            cend_reg      <= '0;
            range_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            neg_reg   <= neg_next;
            pos_reg   <= pos_next;
            cend_reg  <= cend_next;
            range_reg <= range_next;
            if (cmd_pop && cmd.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.last)
        begin
            out_reg <= res_new;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

### hdl/ascii_integer_parser.sv
// channel   dir  beat contents (tdata from bit 0 up)
// --------  ---  ------------------------------------------------------------
// s_axis    in   tdata: character[7:0]; tlast: last character of a string
// m_axis    out  tdata: value[63:0], end_index[76:64], status[78:77], pad[79]
// cfg       in   cfg_we/cfg_data: number_base, taken on any clock with cfg_we
//
// One character per clock unless a stalled m_axis holds a tlast beat, set by the
// back end's 64x6 multiply-accumulate and saturation compare, one per cycle.
// A result shows up after the tlast beat passes the queue and the output register.
// rst_n clears all string state, the queue pointers and the result valid at once.
// A stalled m_axis only holds back tlast beats; other characters keep flowing
// until the queue, two entries deep by default, fills.
module ascii_integer_parser #(
    parameter int MAX_LENGTH  = aip_pkg::MAX_LENGTH_DEF,
    parameter int QUEUE_DEPTH = aip_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // number_base[5:0]
    input  logic                              cfg_we,
    input  logic [aip_pkg::BASE_W-1:0]        cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // character[7:0]
    input  logic [aip_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // value[63:0], end_index[76:64], status[78:77], zero pad[79]
    output logic [aip_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import aip_pkg::*;

    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t q_head;
    logic q_valid;
    logic q_pop;
    res_t res;

    // front: radix register and character classification
    aip_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_char   (s_axis_tdata[CHAR_W-1:0]),
        .in_last   (s_axis_tlast),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    // decouples classification from the accumulate loop
    aip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_head)
    );

    // back: parse state machine, accumulator, result register
    aip_back #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_pop   (q_pop),
        .cmd       (q_head),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {OUT_PAD_W'(0), res.status, res.end_index, res.value};

    // only three status codes ever leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (res.status == STATUS_OK || res.status == STATUS_RANGE ||
                           res.status == STATUS_BADBASE))
        else $error("bad status code on result beat");

    // a bad radix reports nothing parsed
    a_badbase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.status == STATUS_BADBASE) |->
        (res.value == '0 && res.end_index == '0))
        else $error("bad-radix result carries a value");

    // an out-of-range result sits on one of the two limits
    a_range_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.status == STATUS_RANGE) |->
        (res.value == POS_LIMIT || res.value == NEG_LIMIT))
        else $error("saturated result not at a limit");

endmodule
